// ===== rtl/vsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_pkg: shared types and constants
// Sample and phase widths, register indexes, mode codes, and the records
// passed between the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
package vsr_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;

    localparam int STEP_W  = PHASE_FRAC_BITS + 1;
    localparam int PHASE_W = PHASE_FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODEC_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd4;

    localparam logic [1:0] MODE_RESAMPLE = 2'd0;
    localparam logic [1:0] MODE_CODEC    = 2'd1;
    localparam logic [1:0] MODE_SCALED   = 2'd2;

    localparam logic [6:0] VOL_FULL = 7'd100;

    localparam logic [STEP_W-1:0] PHASE_ONE  = STEP_W'(1) << PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0] PHASE_HALF = STEP_W'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64000);

    // Scaled product: sample times an 8-bit signed volume
    localparam int PROD_W = SAMPLE_BITS + 8;

    // Divide by 100 through a reciprocal: q = (mag * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = SAMPLE_BITS + 14;
    localparam int RECIP_W     = RECIP_SHIFT - 6;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

    // Interpolation product: 17-bit difference times unsigned phase
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int IP_W   = DIFF_W + PHASE_W + 1;

    typedef struct packed {
        logic [1:0]        output_mode;
        logic [6:0]        volume_level;
        logic              sound_enable;
        logic              codec_present;
        logic [STEP_W-1:0] phase_step;
    } t_cfg;

    typedef struct packed {
        logic                          resample;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          eob;
    } t_qitem;

endpackage

`default_nettype wire

// ===== rtl/vsr_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_in_if: input sample channel
// Valid/ready channel carrying one mono sample and its end-of-block flag.
// ----------------------------------------------------------------------------
interface vsr_in_if import vsr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_block;

    modport source (output valid, output sample_in, output end_of_block, input ready);
    modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

`default_nettype wire

// ===== rtl/vsr_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_out_if: output sample channel
// Valid/ready channel carrying one result sample and its run/block flags.
// ----------------------------------------------------------------------------
interface vsr_out_if import vsr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_of_run;
    logic                          block_done;

    modport source (output valid, output sample_out, output last_of_run,
                    output block_done, input ready);
    modport sink   (input valid, input sample_out, input last_of_run,
                    input block_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/vsr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_front: accept, classify and volume-scale input samples
// Multiplies by the effective volume, divides by 100 toward zero through a
// reciprocal, and pushes the scaled sample with its path into the queue.
// ----------------------------------------------------------------------------
module vsr_front import vsr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    vsr_in_if.sink      i_in,
    input  wire logic   i_full,
    output logic        o_push,
    output t_qitem      o_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int QF_W = PROD_W + RECIP_W;

    logic [1:0]                    r_state, n_state;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_resample;
    logic                          r_eob;
    logic signed [SAMPLE_BITS-1:0] r_cur;

    logic [6:0]                    vol;
    logic signed [7:0]             vol_s;
    logic                          accept;
    logic                          neg;
    logic [PROD_W-1:0]             mag;
    logic [QF_W-1:0]               qfull;
    logic [SAMPLE_BITS-1:0]        quot;

    // Effective volume: mute, saturate, or full scale with a codec in mode 1
    always_comb begin
        if (!i_cfg.sound_enable) begin
            vol = 7'd0;
        end else if (i_cfg.volume_level > VOL_FULL) begin
            vol = VOL_FULL;
        end else begin
            vol = i_cfg.volume_level;
        end
        if (i_cfg.output_mode == MODE_CODEC && i_cfg.codec_present) begin
            vol = VOL_FULL;
        end
    end

    assign vol_s  = signed'({1'b0, vol});
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == F_IDLE);

    assign neg   = r_prod[PROD_W-1];
    assign mag   = neg ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign qfull = QF_W'(mag) * QF_W'(RECIP);
    assign quot  = qfull[RECIP_SHIFT +: SAMPLE_BITS];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_DIV;
            F_DIV:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod     <= PROD_W'(i_in.sample_in) * PROD_W'(vol_s);
            r_eob      <= i_in.end_of_block;
            r_resample <= !(i_cfg.output_mode == MODE_CODEC ||
                            i_cfg.output_mode == MODE_SCALED);
        end
        if (r_state == F_DIV) begin
            r_cur <= neg ? signed'(-quot) : signed'(quot);
        end
    end

    assign o_push          = (r_state == F_PUSH) && !i_full;
    assign o_item.resample = r_resample;
    assign o_item.sample   = r_cur;
    assign o_item.eob      = r_eob;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("front pushed into a full queue");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV) |=> (r_state == F_PUSH))
        else $error("front skipped the push step");

endmodule

`default_nettype wire

// ===== rtl/vsr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_queue: two-entry item queue
// Decouples the scaling front end from the resampling back end.
// ----------------------------------------------------------------------------
module vsr_queue import vsr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qitem i_item,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_qitem      o_item
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_qitem             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH)) else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/vsr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsr_back: passthrough and linear-interpolation engine
// Pops scaled samples, emits one result for passthrough, or one or two
// interpolated results while advancing the 0.16 phase in resample mode.
// ----------------------------------------------------------------------------
module vsr_back import vsr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_empty,
    input  wire t_qitem i_item,
    output logic        o_pop,
    vsr_out_if.source   o_out
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic                          r_rs;
    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic                          r_eob;
    logic signed [IP_W-1:0]        r_ip;

    // Resampler state
    logic [PHASE_W-1:0]            r_phase;
    logic signed [SAMPLE_BITS-1:0] r_prev;

    // Output register
    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_osample;
    logic                          r_olast;
    logic                          r_odone;

    logic [STEP_W-1:0]             step;
    logic [STEP_W-1:0]             acc;
    logic                          more;
    logic                          slot_free;
    logic                          emit;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [PHASE_W:0]       phase_s;
    logic signed [SAMPLE_BITS-1:0] interp;
    logic signed [SAMPLE_BITS-1:0] res;
    logic                          last;

    // Clamp the step to half..one input period
    always_comb begin
        if (i_cfg.phase_step < PHASE_HALF) begin
            step = PHASE_HALF;
        end else if (i_cfg.phase_step > PHASE_ONE) begin
            step = PHASE_ONE;
        end else begin
            step = i_cfg.phase_step;
        end
    end

    assign acc  = STEP_W'(r_phase) + step;
    assign more = r_rs && !acc[PHASE_FRAC_BITS];

    assign diff    = DIFF_W'(r_cur) - DIFF_W'(r_prev);
    assign phase_s = signed'({1'b0, r_phase});
    assign interp  = r_prev + r_ip[PHASE_FRAC_BITS +: SAMPLE_BITS];
    assign res     = r_rs ? interp : r_cur;
    assign last    = !more;

    assign slot_free = !r_ov || o_out.ready;
    assign emit      = (r_state == B_OUT) && slot_free;
    assign o_pop     = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = i_item.resample ? B_MUL : B_OUT;
            B_MUL:  n_state = B_OUT;
            B_OUT:  if (slot_free) n_state = more ? B_MUL : B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_phase <= '0;
            r_prev  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            // Advance the phase after every interpolated result; the wrap by
            // one period falls out of dropping the integer bit
            if (emit && r_rs) begin
                r_phase <= acc[PHASE_W-1:0];
                if (!more) r_prev <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rs  <= i_item.resample;
            r_cur <= i_item.sample;
            r_eob <= i_item.eob;
        end
        if (r_state == B_MUL) begin
            r_ip <= IP_W'(diff) * IP_W'(phase_s);
        end
        if (emit) begin
            r_osample <= res;
            r_olast   <= last;
            r_odone   <= last && r_eob;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.sample_out  = r_osample;
    assign o_out.last_of_run = r_olast;
    assign o_out.block_done  = r_odone;

    a_mul_resample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |-> r_rs) else $error("interpolation on passthrough item");

    a_done_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.block_done) |-> o_out.last_of_run)
        else $error("block_done without last_of_run");

endmodule

`default_nettype wire

// ===== rtl/volume_scale_linear_resampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// volume_scale_linear_resampler: volume scaler with linear resampler
// Scales signed mono samples by volume/100 and either passes them through or
// resamples them by linear interpolation on a 0.16 phase.
// ----------------------------------------------------------------------------
// Usage
//   i_in   : valid/ready input channel, one mono sample plus end_of_block.
//   o_out  : valid/ready output channel; each input yields one result in the
//            passthrough modes and one or two results in resample mode. The
//            last result of an input carries last_of_run, and block_done
//            when the input had end_of_block set.
//   i_cfg_*: register writes, taken on any rising edge with i_cfg_we high;
//            only write while the block is idle.
// Sequencing
//   The front end accepts an item with the volume multiply, divides by 100
//   through the reciprocal, then pushes to the queue, and takes no new input
//   until that push is done. The back end pops an item and registers a
//   passthrough result directly; in resample mode every result first passes
//   through its single difference-times-phase multiplier, which limits how
//   soon the second result of an input can follow the first.
// Reset and stall
//   Reset loads the register defaults, zeroes the phase and the previous
//   sample and empties the queue. A stalled receiver holds the output
//   register; the two-entry queue fills and the front end holds one more
//   item in its push step, keeping ready low until the queue has room.
// ----------------------------------------------------------------------------
module volume_scale_linear_resampler import vsr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    vsr_in_if.sink                     i_in,
    vsr_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_qitem push_item;
    t_qitem head_item;

    // Configuration registers; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_mode   <= MODE_RESAMPLE;
            r_cfg.volume_level  <= VOL_FULL;
            r_cfg.sound_enable  <= 1'b1;
            r_cfg.codec_present <= 1'b0;
            r_cfg.phase_step    <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUTPUT_MODE:   r_cfg.output_mode   <= i_cfg_data[1:0];
                REG_VOLUME_LEVEL:  r_cfg.volume_level  <= i_cfg_data[6:0];
                REG_SOUND_ENABLE:  r_cfg.sound_enable  <= i_cfg_data[0];
                REG_CODEC_PRESENT: r_cfg.codec_present <= i_cfg_data[0];
                REG_PHASE_STEP:    r_cfg.phase_step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: accept, classify, scale
    vsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    // Queue between the two halves
    vsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    // Back end: passthrough or interpolation, output register
    vsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
